FILE: sv/stsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package stsc_pkg;

  localparam int LAMP_COUNT_DEF    = 6;
  localparam int BOTTOM_COUNT_DEF  = 3;
  localparam int STEPS_PER_BAR_DEF = 16;

  localparam int MODE_W   = 2;
  localparam int NOW_W    = 32;
  localparam int CMD_W    = 3;
  localparam int LAMPS_W  = 6;
  localparam int MET_W    = 8;
  localparam int HITS_W   = 5;
  localparam int S_W      = 16;
  localparam int Q_W      = S_W + 2;
  localparam int PROD_W   = MET_W + Q_W;
  localparam int DIV_W    = 3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = S_W;

  localparam logic [CFG_IDX_W-1:0] CFG_SIXTEENTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIVISION  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_METER_MAX = 2'd2;

  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_START = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STOP  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CMD   = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [NOW_W-1:0]  now_ms;
    logic [CMD_W-1:0]  lamp_command;
  } in_word_t;

  typedef struct packed {
    logic [LAMPS_W-1:0] lamps;
    logic [MET_W-1:0]   meter_level;
    logic [HITS_W-1:0]  division_hits;
  } out_word_t;

endpackage
`default_nettype wire

FILE: sv/tempo_synced_spotlight_chaser_unit.sv
// Flow: S_IDLE accepts a word, S_EXEC runs it and S_DONE loads the result; a running tick
// adds S_METER, and inside its quarter note also S_MUL, S_START and S_DIV (8 steps of the
// restoring divider). One word in flight; the next is accepted once the result is loaded
// and the unit is back in S_IDLE, so any output stall holds off the next word.
// Reset: synchronous, active low; clears control, config registers and lamp state.
`timescale 1ns / 1ps
`default_nettype none
module tempo_synced_spotlight_chaser_unit #(
  parameter int LAMP_COUNT    = stsc_pkg::LAMP_COUNT_DEF,
  parameter int BOTTOM_COUNT  = stsc_pkg::BOTTOM_COUNT_DEF,
  parameter int STEPS_PER_BAR = stsc_pkg::STEPS_PER_BAR_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  stsc_pkg::in_word_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output stsc_pkg::out_word_t             out_data,
  input  logic                            cfg_we,
  input  logic [stsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stsc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import stsc_pkg::*;

  localparam int IDX_W  = $clog2(LAMP_COUNT);
  localparam int WIDE_W = IDX_W + 1;
  localparam int SC_W   = $clog2(STEPS_PER_BAR);
  localparam int SC_X   = SC_W + 1;

  localparam int F_TOP   = 0;
  localparam int F_BOT   = 1;
  localparam int F_BLINK = 2;
  localparam int F_SEQ   = 3;

  localparam logic [HITS_W-1:0] HITS_16 = 5'h01;
  localparam logic [HITS_W-1:0] HITS_8  = 5'h03;
  localparam logic [HITS_W-1:0] HITS_4  = 5'h07;
  localparam logic [HITS_W-1:0] HITS_2  = 5'h0F;
  localparam logic [HITS_W-1:0] HITS_1  = 5'h1F;

  localparam logic [S_W-1:0]   SIXTEENTH_RST = 16'd125;
  localparam logic [DIV_W-1:0] DIVISION_RST  = 3'd2;
  localparam logic [MET_W-1:0] METER_MAX_RST = 8'd255;

  function automatic logic [LAMPS_W-1:0] lamp_mask(input int n);
    logic [LAMPS_W-1:0] m;
    for (int i = 0; i < LAMPS_W; i++) m[i] = (i < n);
    return m;
  endfunction

  localparam logic [LAMPS_W-1:0] ALL_MASK = lamp_mask(LAMP_COUNT);
  localparam logic [LAMPS_W-1:0] BOT_MASK = lamp_mask(BOTTOM_COUNT) & ALL_MASK;
  localparam logic [LAMPS_W-1:0] TOP_MASK = ALL_MASK & ~BOT_MASK;

  function automatic logic [LAMPS_W-1:0] lamp_put(input logic [LAMPS_W-1:0] b,
                                                  input logic [WIDE_W-1:0] idx,
                                                  input logic on);
    logic [LAMPS_W-1:0] r;
    r = b;
    for (int i = 0; i < LAMPS_W; i++) begin
      if (i < LAMP_COUNT && idx == WIDE_W'(i)) r[i] = on;
    end
    return r;
  endfunction

  function automatic logic [LAMPS_W-1:0] group_put(input logic [LAMPS_W-1:0] b,
                                                   input logic [LAMPS_W-1:0] m,
                                                   input logic on);
    return on ? (b | m) : (b & ~m);
  endfunction

  function automatic logic [LAMPS_W-1:0] blink_put(input logic [LAMPS_W-1:0] b,
                                                   input logic [3:0] fl,
                                                   input logic ph);
    logic [LAMPS_W-1:0] r;
    r = b;
    if (fl[F_BOT]) begin
      r = group_put(r, BOT_MASK, ph);
      if (fl[F_TOP]) r = group_put(r, TOP_MASK, !ph);
    end else if (fl[F_TOP]) begin
      r = group_put(r, TOP_MASK, ph);
    end else begin
      r = group_put(r, ALL_MASK, ph);
    end
    return r;
  endfunction

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_METER, S_MUL, S_START, S_DIV, S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  in_word_t           in_r, in_nxt;
  out_word_t          out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [S_W-1:0]     sixteenth_r;
  logic [DIV_W-1:0]   division_r;
  logic [MET_W-1:0]   meter_max_r;

  logic               running_r, running_nxt;
  logic               resync_r, resync_nxt;
  logic               clear_r, clear_nxt;
  logic [NOW_W-1:0]   last_step_r, last_step_nxt;
  logic [NOW_W-1:0]   last_beat_r, last_beat_nxt;
  logic [SC_W-1:0]    step_r, step_nxt;
  logic [3:0]         flags_r, flags_nxt;
  logic               setup_r, setup_nxt;
  logic               phase_r, phase_nxt;
  logic [IDX_W-1:0]   chase_r, chase_nxt;
  logic [LAMPS_W-1:0] lamps_r, lamps_nxt;

  logic [HITS_W-1:0]  hits_r, hits_nxt;
  logic [MET_W-1:0]   meter_r, meter_nxt;
  logic [Q_W-1:0]     num_r, num_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;

  logic               div_start;
  logic               div_done;
  logic [MET_W-1:0]   div_quot;
  logic [Q_W-1:0]     quarter;

  logic [IDX_W-1:0]   fwd_bot [2**WIDE_W];

  for (genvar g = 0; g < 2**WIDE_W; g++) begin : g_fwd_bot
    assign fwd_bot[g] = IDX_W'(g % BOTTOM_COUNT);
  end

  assign quarter = {sixteenth_r, 2'b00};

  stsc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (quarter),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sixteenth_r <= SIXTEENTH_RST;
      division_r  <= DIVISION_RST;
      meter_max_r <= METER_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SIXTEENTH: sixteenth_r <= cfg_wdata;
        CFG_DIVISION:  division_r  <= cfg_wdata[DIV_W-1:0];
        CFG_METER_MAX: meter_max_r <= cfg_wdata[MET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [LAMPS_W-1:0] lamps_v;
    logic [IDX_W-1:0]   c;
    logic [WIDE_W-1:0]  cp1;
    logic               phase_v;
    logic [NOW_W-1:0]   ls_v;
    logic [NOW_W-1:0]   diff_v;
    logic [NOW_W-1:0]   e_v;
    logic [SC_X-1:0]    inc_v;
    logic [7:0]         inc8;
    logic [HITS_W-1:0]  hits_v;
    logic [3:0]         flag_v;
    logic               fire_v;

    state_nxt     = state_r;
    in_nxt        = in_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    running_nxt   = running_r;
    resync_nxt    = resync_r;
    clear_nxt     = clear_r;
    last_step_nxt = last_step_r;
    last_beat_nxt = last_beat_r;
    step_nxt      = step_r;
    flags_nxt     = flags_r;
    setup_nxt     = setup_r;
    phase_nxt     = phase_r;
    chase_nxt     = chase_r;
    lamps_nxt     = lamps_r;
    hits_nxt      = hits_r;
    meter_nxt     = meter_r;
    num_nxt       = num_r;
    prod_nxt      = prod_r;
    div_start     = 1'b0;

    lamps_v = lamps_r;
    c       = chase_r;
    cp1     = '0;
    phase_v = phase_r;
    ls_v    = last_step_r;
    diff_v  = '0;
    e_v     = '0;
    inc_v   = '0;
    inc8    = '0;
    hits_v  = '0;
    flag_v  = '0;
    fire_v  = 1'b0;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          in_nxt    = in_data;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        hits_nxt  = '0;
        meter_nxt = '0;
        state_nxt = S_DONE;
        unique case (in_r.mode)
          MODE_START: begin
            if (!running_r) begin
              running_nxt = 1'b1;
              resync_nxt  = 1'b1;
            end
          end
          MODE_STOP: begin
            if (running_r) begin
              running_nxt = 1'b0;
              clear_nxt   = 1'b1;
            end
          end
          MODE_CMD: begin
            flag_v    = 4'b0001 << in_r.lamp_command[2:1];
            flags_nxt = in_r.lamp_command[0] ? (flags_r & ~flag_v) : (flags_r | flag_v);
            setup_nxt = 1'b1;
          end
          MODE_TICK: begin
            if (resync_r) ls_v = in_r.now_ms;
            resync_nxt = 1'b0;
            // re-layout lamps after a command
            if (setup_r) begin
              setup_nxt = 1'b0;
              lamps_v   = '0;
              if (flags_r[F_SEQ]) begin
                if (flags_r[F_BOT]) begin
                  if (flags_r[F_TOP]) begin
                    lamps_v = lamp_put(lamps_v, WIDE_W'(c) + WIDE_W'(BOTTOM_COUNT), 1'b1);
                  end else if (c >= IDX_W'(BOTTOM_COUNT)) begin
                    c = flags_r[F_BLINK] ? IDX_W'(BOTTOM_COUNT - 1) : '0;
                  end
                end else if (flags_r[F_TOP] && c < IDX_W'(BOTTOM_COUNT)) begin
                  c = flags_r[F_BLINK] ? IDX_W'(LAMP_COUNT - 1) : IDX_W'(BOTTOM_COUNT);
                end
                lamps_v = lamp_put(lamps_v, WIDE_W'(c), 1'b1);
              end else if (flags_r[F_BLINK]) begin
                phase_v = 1'b1;
                lamps_v = blink_put(lamps_v, flags_r, 1'b1);
              end else begin
                if (flags_r[F_TOP]) lamps_v = lamps_v | TOP_MASK;
                if (flags_r[F_BOT]) lamps_v = lamps_v | BOT_MASK;
              end
            end
            // note clock
            diff_v = in_r.now_ms - ls_v;
            if (diff_v >= NOW_W'(sixteenth_r)) begin
              ls_v  = ls_v + NOW_W'(sixteenth_r);
              inc_v = SC_X'(step_r) + 1'b1;
              inc8  = 8'(inc_v);
              if (inc_v >= SC_X'(STEPS_PER_BAR)) begin
                step_nxt = '0;
                hits_v   = HITS_1;
              end else begin
                step_nxt = inc_v[SC_W-1:0];
                if (inc8[2:0] == 3'd0) hits_v = HITS_2;
                else if (inc8[1:0] == 2'd0) hits_v = HITS_4;
                else if (inc8[0] == 1'b0) hits_v = HITS_8;
                else hits_v = HITS_16;
              end
              if (hits_v[2]) last_beat_nxt = in_r.now_ms;
            end
            last_step_nxt = ls_v;
            hits_nxt      = hits_v;
            // step lamps on the selected division
            fire_v = (division_r < DIV_W'(HITS_W)) && hits_v[division_r];
            if (fire_v) begin
              if (flags_r[F_SEQ]) begin
                lamps_v = lamp_put(lamps_v, WIDE_W'(c), 1'b0);
                cp1     = WIDE_W'(c) + WIDE_W'(1);
                if (flags_r[F_BOT]) begin
                  if (flags_r[F_TOP])
                    lamps_v = lamp_put(lamps_v, WIDE_W'(c) + WIDE_W'(BOTTOM_COUNT), 1'b0);
                  if (flags_r[F_BLINK]) begin
                    c = (c == '0 || c > IDX_W'(BOTTOM_COUNT)) ?
                        IDX_W'(BOTTOM_COUNT - 1) : c - 1'b1;
                  end else begin
                    c = fwd_bot[cp1];
                  end
                  if (flags_r[F_TOP])
                    lamps_v = lamp_put(lamps_v, WIDE_W'(c) + WIDE_W'(BOTTOM_COUNT), 1'b1);
                end else if (flags_r[F_TOP]) begin
                  if (flags_r[F_BLINK]) begin
                    c = (c <= IDX_W'(BOTTOM_COUNT)) ? IDX_W'(LAMP_COUNT - 1) : c - 1'b1;
                  end else begin
                    c = (cp1 >= WIDE_W'(LAMP_COUNT)) ? IDX_W'(BOTTOM_COUNT) : cp1[IDX_W-1:0];
                  end
                end else begin
                  if (flags_r[F_BLINK]) begin
                    c = (c == '0) ? IDX_W'(LAMP_COUNT - 1) : c - 1'b1;
                  end else begin
                    c = (cp1 == WIDE_W'(LAMP_COUNT)) ? '0 : cp1[IDX_W-1:0];
                  end
                end
                lamps_v = lamp_put(lamps_v, WIDE_W'(c), 1'b1);
              end else if (flags_r[F_BLINK]) begin
                phase_v = !phase_v;
                lamps_v = blink_put(lamps_v, flags_r, phase_v);
              end
            end
            // drop lamps once after a stop
            if (!running_r && clear_r) begin
              lamps_v   = '0;
              clear_nxt = 1'b0;
            end
            lamps_nxt = lamps_v;
            chase_nxt = c;
            phase_nxt = phase_v;
            if (running_r) state_nxt = S_METER;
          end
          default: ;
        endcase
      end
      S_METER: begin
        e_v = in_r.now_ms - last_beat_r;
        if (quarter != '0 && e_v < NOW_W'(quarter)) begin
          num_nxt   = quarter - e_v[Q_W-1:0];
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MUL: begin
        prod_nxt  = PROD_W'(meter_max_r) * PROD_W'(num_r);
        state_nxt = S_START;
      end
      S_START: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          meter_nxt = div_quot;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.lamps         = lamps_r;
          out_nxt.meter_level   = meter_r;
          out_nxt.division_hits = hits_r;
          out_valid_nxt         = 1'b1;
          state_nxt             = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      running_r   <= 1'b0;
      resync_r    <= 1'b1;
      clear_r     <= 1'b0;
      last_step_r <= '0;
      last_beat_r <= '0;
      step_r      <= '0;
      flags_r     <= '0;
      setup_r     <= 1'b0;
      phase_r     <= 1'b0;
      chase_r     <= '0;
      lamps_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      running_r   <= running_nxt;
      resync_r    <= resync_nxt;
      clear_r     <= clear_nxt;
      last_step_r <= last_step_nxt;
      last_beat_r <= last_beat_nxt;
      step_r      <= step_nxt;
      flags_r     <= flags_nxt;
      setup_r     <= setup_nxt;
      phase_r     <= phase_nxt;
      chase_r     <= chase_nxt;
      lamps_r     <= lamps_nxt;
    end
    in_r    <= in_nxt;
    out_r   <= out_nxt;
    hits_r  <= hits_nxt;
    meter_r <= meter_nxt;
    num_r   <= num_nxt;
    prod_r  <= prod_nxt;
  end

  assign in_stall  = (state_r != S_IDLE) || !rst_n;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

FILE: sv/stsc_div.sv
`timescale 1ns / 1ps
`default_nettype none
module stsc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [stsc_pkg::PROD_W-1:0] dividend,
  input  logic [stsc_pkg::Q_W-1:0]    divisor,
  output logic                       done,
  output logic [stsc_pkg::MET_W-1:0]  quotient
);
  import stsc_pkg::*;

  localparam int CNT_W = $clog2(MET_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [Q_W-1:0]   rem_r;
  logic [MET_W-1:0] quo_r;
  logic [Q_W:0]     trial;
  logic             ge;

  assign trial = {rem_r, quo_r[MET_W-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MET_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (start) begin
      rem_r <= dividend[PROD_W-1:MET_W];
      quo_r <= dividend[MET_W-1:0];
    end else if (busy_r) begin
      rem_r <= ge ? Q_W'(trial - {1'b0, divisor}) : trial[Q_W-1:0];
      quo_r <= {quo_r[MET_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

FILE: sv/stsc_chk.sv
`timescale 1ns / 1ps
`default_nettype none
module stsc_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input stsc_pkg::out_word_t out_data
);
  import stsc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous word in work");

  a_hits_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.division_hits == 5'h00 || out_data.division_hits == 5'h01 ||
                   out_data.division_hits == 5'h03 || out_data.division_hits == 5'h07 ||
                   out_data.division_hits == 5'h0F || out_data.division_hits == 5'h1F))
    else $error("division hits not nested");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind tempo_synced_spotlight_chaser_unit stsc_chk u_stsc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
